// ===== hdl/polygon_perimeter_assert.svh =====
// ---------------------------------------------------------------------------
// polygon_perimeter_assert.svh
// assertion macros shared by the checker; both sample on clk, quiet in reset
// ---------------------------------------------------------------------------
`ifndef POLYGON_PERIMETER_ASSERT_SVH
`define POLYGON_PERIMETER_ASSERT_SVH

// same-cycle implication
`define PP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pp_pkg.sv =====
// ---------------------------------------------------------------------------
// pp_pkg
// widths, step counts and state codes of the polygon perimeter block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pp_pkg;

  // field widths
  localparam int COORD_BITS     = 16;
  localparam int FRAC_BITS      = 8;
  localparam int SUM_BITS       = 48;
  localparam int IN_TDATA_BITS  = 2 * COORD_BITS;
  localparam int OUT_TDATA_BITS = ((SUM_BITS + 7) / 8) * 8;

  // sum of two squared magnitudes, then the radicand with the fraction shift
  localparam int SQ_BITS   = 2 * COORD_BITS + 1;
  localparam int RAD_PAIRS = (SQ_BITS + 2 * FRAC_BITS + 1) / 2;
  localparam int RAD_BITS  = 2 * RAD_PAIRS;
  localparam int ROOT_BITS = RAD_PAIRS;
  localparam int REM_BITS  = ROOT_BITS + 2;

  // step counter covers the multiply and the root passes
  localparam int STEP_MAX  = (ROOT_BITS > COORD_BITS) ? ROOT_BITS : COORD_BITS;
  localparam int STEP_BITS = $clog2(STEP_MAX);

  // vertex count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_MANY = 2'd2;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ROOT = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

endpackage

// ===== hdl/polygon_perimeter.sv =====
// ---------------------------------------------------------------------------
// polygon_perimeter
// Euclidean perimeter of a closed polygon in fixed point, bit-serial datapath
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one vertex per transfer, x in tdata[15:0], y in tdata[31:16],
//           tlast marks the final vertex of the polygon.
//   out_* : one perimeter per polygon, 48 bits with 8 fraction bits in tdata,
//           tuser set when the running sum was clamped at its maximum.
// Sequence:
//   the first vertex of a polygon is only stored. every further vertex runs
//   one edge: shift-add squaring (one multiplier bit per cycle), restoring
//   square root (one radicand bit pair per cycle) and an accumulate step.
//   the last vertex also runs the closing edge back to the first vertex and
//   then loads the output register. a lone last vertex gives 0.
//   one vertex is in work at a time; in_tready is high only when idle.
// Reset:
//   rst_n low clears the vertex count, the sum, the clamp flag and out_tvalid.
// Stall:
//   a result waits in the output register; new vertices are still taken and
//   the next result holds back until the waiting one has been transferred.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module polygon_perimeter (
  input  logic                              clk,
  input  logic                              rst_n,
  // vertex input
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pp_pkg::IN_TDATA_BITS-1:0]  in_tdata,   // x_coord, y_coord
  input  logic                              in_tlast,   // last_point
  // perimeter output
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pp_pkg::OUT_TDATA_BITS-1:0] out_tdata,  // perimeter
  output logic                              out_tuser   // saturated
);

  localparam int CB = pp_pkg::COORD_BITS;

  pp_pkg::state_t state_r, state_nxt;

  logic [CB-1:0]                  first_x_r, first_x_nxt, first_y_r, first_y_nxt;
  logic [CB-1:0]                  prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [1:0]                     count_r, count_nxt;
  logic [pp_pkg::SUM_BITS-1:0]    sum_r, sum_nxt;
  logic                           clamped_r, clamped_nxt;
  logic                           last_r, last_nxt;
  logic                           close_r, close_nxt;
  logic [pp_pkg::STEP_BITS-1:0]   step_r, step_nxt;
  logic                           out_valid_r, out_valid_nxt;

  logic [pp_pkg::SQ_BITS-1:0]     ax_r, ax_nxt, ay_r, ay_nxt;
  logic [CB-1:0]                  bx_r, bx_nxt, by_r, by_nxt;
  logic [pp_pkg::SQ_BITS-1:0]     sq_r, sq_nxt;
  logic [pp_pkg::RAD_BITS-1:0]    rad_r, rad_nxt;
  logic [pp_pkg::REM_BITS-1:0]    rem_r, rem_nxt;
  logic [pp_pkg::ROOT_BITS-1:0]   root_r, root_nxt;
  logic [pp_pkg::SUM_BITS-1:0]    out_data_r, out_data_nxt;
  logic                           out_sat_r, out_sat_nxt;

  logic                           in_xfer;
  logic [CB-1:0]                  in_x, in_y;
  logic [CB-1:0]                  opa_x, opa_y, opb_x, opb_y;
  logic [CB:0]                    diff_x, diff_y;
  logic [CB-1:0]                  mag_x, mag_y;
  logic [pp_pkg::SQ_BITS-1:0]     sq_step;
  logic [pp_pkg::REM_BITS-1:0]    rem_sh, trial;
  logic [pp_pkg::SUM_BITS:0]      sum_ext;

  assign in_tready  = (state_r == pp_pkg::ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign in_x       = in_tdata[CB-1:0];
  assign in_y       = in_tdata[2*CB-1:CB];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = pp_pkg::OUT_TDATA_BITS'(out_data_r);
  assign out_tuser  = out_sat_r;

  // edge operands: new vertex against previous, or closing edge back to first
  always_comb begin
    opa_x = prev_x_r;
    opa_y = prev_y_r;
    opb_x = (state_r == pp_pkg::ST_ACC) ? first_x_r : in_x;
    opb_y = (state_r == pp_pkg::ST_ACC) ? first_y_r : in_y;
  end

  // signed differences and their magnitudes
  assign diff_x = {opb_x[CB-1], opb_x} - {opa_x[CB-1], opa_x};
  assign diff_y = {opb_y[CB-1], opb_y} - {opa_y[CB-1], opa_y};
  assign mag_x  = diff_x[CB] ? CB'(-diff_x) : diff_x[CB-1:0];
  assign mag_y  = diff_y[CB] ? CB'(-diff_y) : diff_y[CB-1:0];

  // one multiplier bit of both squares per cycle
  assign sq_step = sq_r + (bx_r[0] ? ax_r : '0) + (by_r[0] ? ay_r : '0);

  // one radicand bit pair of the root per cycle
  assign rem_sh = {rem_r[pp_pkg::REM_BITS-3:0], rad_r[pp_pkg::RAD_BITS-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  // running sum with the carry as overflow
  assign sum_ext = {1'b0, sum_r} + (pp_pkg::SUM_BITS + 1)'(root_r);

  // sequencer and datapath next values
  always_comb begin
    state_nxt     = state_r;
    first_x_nxt   = first_x_r;
    first_y_nxt   = first_y_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    clamped_nxt   = clamped_r;
    last_nxt      = last_r;
    close_nxt     = close_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    sq_nxt        = sq_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    out_data_nxt  = out_data_r;
    out_sat_nxt   = out_sat_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      pp_pkg::ST_IDLE: begin
        if (in_xfer) begin
          prev_x_nxt = in_x;
          prev_y_nxt = in_y;
          last_nxt   = in_tlast;
          if (count_r == pp_pkg::CNT_NONE) begin
            first_x_nxt = in_x;
            first_y_nxt = in_y;
            count_nxt   = pp_pkg::CNT_ONE;
            if (in_tlast) begin
              state_nxt = pp_pkg::ST_EMIT;
            end
          end else begin
            count_nxt = pp_pkg::CNT_MANY;
            close_nxt = in_tlast;
            ax_nxt    = pp_pkg::SQ_BITS'(mag_x);
            ay_nxt    = pp_pkg::SQ_BITS'(mag_y);
            bx_nxt    = mag_x;
            by_nxt    = mag_y;
            sq_nxt    = '0;
            step_nxt  = pp_pkg::STEP_BITS'(CB - 1);
            state_nxt = pp_pkg::ST_MUL;
          end
        end
      end
      pp_pkg::ST_MUL: begin
        sq_nxt = sq_step;
        ax_nxt = {ax_r[pp_pkg::SQ_BITS-2:0], 1'b0};
        ay_nxt = {ay_r[pp_pkg::SQ_BITS-2:0], 1'b0};
        bx_nxt = {1'b0, bx_r[CB-1:1]};
        by_nxt = {1'b0, by_r[CB-1:1]};
        step_nxt = step_r - pp_pkg::STEP_BITS'(1);
        if (step_r == '0) begin
          rad_nxt   = pp_pkg::RAD_BITS'({sq_step, {(2 * pp_pkg::FRAC_BITS){1'b0}}});
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = pp_pkg::STEP_BITS'(pp_pkg::ROOT_BITS - 1);
          state_nxt = pp_pkg::ST_ROOT;
        end
      end
      pp_pkg::ST_ROOT: begin
        rad_nxt = {rad_r[pp_pkg::RAD_BITS-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[pp_pkg::ROOT_BITS-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[pp_pkg::ROOT_BITS-2:0], 1'b0};
        end
        step_nxt = step_r - pp_pkg::STEP_BITS'(1);
        if (step_r == '0) begin
          state_nxt = pp_pkg::ST_ACC;
        end
      end
      pp_pkg::ST_ACC: begin
        if (sum_ext[pp_pkg::SUM_BITS]) begin
          sum_nxt     = '1;
          clamped_nxt = 1'b1;
        end else begin
          sum_nxt = sum_ext[pp_pkg::SUM_BITS-1:0];
        end
        if (close_r) begin
          // closing edge from the last vertex back to the first
          close_nxt = 1'b0;
          ax_nxt    = pp_pkg::SQ_BITS'(mag_x);
          ay_nxt    = pp_pkg::SQ_BITS'(mag_y);
          bx_nxt    = mag_x;
          by_nxt    = mag_y;
          sq_nxt    = '0;
          step_nxt  = pp_pkg::STEP_BITS'(CB - 1);
          state_nxt = pp_pkg::ST_MUL;
        end else if (last_r) begin
          state_nxt = pp_pkg::ST_EMIT;
        end else begin
          state_nxt = pp_pkg::ST_IDLE;
        end
      end
      pp_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = (count_r == pp_pkg::CNT_MANY) ? sum_r : '0;
          out_sat_nxt   = (count_r == pp_pkg::CNT_MANY) && clamped_r;
          out_valid_nxt = 1'b1;
          first_x_nxt   = '0;
          first_y_nxt   = '0;
          prev_x_nxt    = '0;
          prev_y_nxt    = '0;
          count_nxt     = pp_pkg::CNT_NONE;
          sum_nxt       = '0;
          clamped_nxt   = 1'b0;
          last_nxt      = 1'b0;
          close_nxt     = 1'b0;
          state_nxt     = pp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pp_pkg::ST_IDLE;
      end
    endcase
  end

  // control and polygon state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pp_pkg::ST_IDLE;
      first_x_r   <= '0;
      first_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      count_r     <= pp_pkg::CNT_NONE;
      sum_r       <= '0;
      clamped_r   <= 1'b0;
      last_r      <= 1'b0;
      close_r     <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_x_r   <= first_x_nxt;
      first_y_r   <= first_y_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      clamped_r   <= clamped_nxt;
      last_r      <= last_nxt;
      close_r     <= close_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // shift registers of the serial datapath and the output register
  always_ff @(posedge clk) begin
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    bx_r       <= bx_nxt;
    by_r       <= by_nxt;
    sq_r       <= sq_nxt;
    rad_r      <= rad_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    out_data_r <= out_data_nxt;
    out_sat_r  <= out_sat_nxt;
  end

endmodule

// ===== hdl/pp_checker.sv =====
// ---------------------------------------------------------------------------
// pp_checker
// port-level checks on the polygon perimeter block, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polygon_perimeter_assert.svh"

module pp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [pp_pkg::OUT_TDATA_BITS-1:0] out_tdata,
  input logic                              out_tuser
);

  logic out_stall;
  logic out_at_max;

  // result offered but not taken, and result at the top of the range
  assign out_stall  = out_tvalid && !out_tready;
  assign out_at_max = (out_tdata[pp_pkg::SUM_BITS-1:0] == {pp_pkg::SUM_BITS{1'b1}});

  // a stalled result stays offered
  `PP_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid, "result dropped while stalled")

  // a stalled result keeps its payload
  `PP_ASSERT_NEXT(a_out_stable, out_stall, $stable({out_tdata, out_tuser}), "result changed")

  // a clamped sum reads as all ones
  `PP_ASSERT_NOW(a_sat_max, out_tvalid && out_tuser, out_at_max, "clamped result not at max")

  // a new result is only loaded while the input side is closed
  `PP_ASSERT_NOW(a_emit_busy, $rose(out_tvalid), !$past(in_tready), "result loaded while open")

endmodule

bind polygon_perimeter pp_checker u_pp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
